>>> src/all_pairs_shortest_path_johnson_core_defines.svh
// Assertion macros used by the port checker of the shortest path core.
`ifndef ALL_PAIRS_SHORTEST_PATH_JOHNSON_CORE_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_JOHNSON_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define APSPJ_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shortest path core: assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define APSPJ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shortest path core: assertion failed");

`endif

>>> src/apspj_pkg.sv
// Package with the types, constants and codes of the shortest path core.
`timescale 1ns / 1ps
`default_nettype none
package apspj_pkg;
	localparam int MAX_VERTICES = 16;
	localparam int MAX_EDGES    = 64;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int EIDX_W       = $clog2(MAX_EDGES);
	localparam int ECNT_W       = $clog2(MAX_EDGES + 1);
	localparam int VCNT_W       = 5;
	localparam int TIDX_W       = 2 * VIDX_W;
	localparam int DIST_W       = 32;
	localparam logic signed [DIST_W-1:0] UNREACHABLE = 32'sd1000000000;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_CYCLE   = 2'd2;
	localparam logic [1:0] ST_NOT_RUN = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [4:0]         edge_from;
		logic [4:0]         edge_to;
		logic signed [15:0] edge_weight;
		logic [4:0]         query_row;
		logic [4:0]         query_col;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DIST_W-1:0] distance;
	} rsp_t;

	typedef struct packed {
		logic [4:0]         src;
		logic [4:0]         dst;
		logic signed [15:0] w;
	} edge_t;

	typedef enum logic [1:0] {PH_POT, PH_CHK, PH_SRC} phase_t;

	typedef enum logic [1:0] {OUT_ADD, OUT_ZERO, OUT_RUN, OUT_QUERY} out_sel_t;

	typedef enum logic [3:0] {
		S_IDLE, S_QRD, S_CLR, S_PASS, S_ERD, S_EVAL, S_EUPD,
		S_CHKD, S_SINIT, S_RRD, S_RWR, S_DONE
	} state_t;

	typedef struct packed {
		logic              add_edge;
		logic              clear_edges;
		logic              query;
		logic              run_start;
		logic              set_ready;
		logic              set_cycle;
		logic              reach_all;
		logic              val_clr;
		logic              src_init;
		logic              edge_rd;
		logic              val_rd;
		logic              relax_wr;
		logic              row_rd;
		logic              row_wr;
		logic              out_ld;
		out_sel_t          out_sel;
		logic [EIDX_W-1:0] k;
		logic [VIDX_W-1:0] s;
		logic [VIDX_W-1:0] t;
	} cmd_t;

	typedef struct packed {
		logic [ECNT_W-1:0] edge_total;
		logic [VCNT_W-1:0] n;
		logic              relax;
		logic              cycle;
	} sts_t;
endpackage
`default_nettype wire

>>> src/apspj_dp.sv
// Datapath: edge store, vertex value store, distance table and result register.
`timescale 1ns / 1ps
`default_nettype none
module apspj_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire apspj_pkg::req_t   req,
	input  wire logic              cfg_we,
	input  wire logic [4:0]        cfg_wdata,
	input  wire apspj_pkg::cmd_t   cmd,
	output apspj_pkg::sts_t        sts,
	output apspj_pkg::rsp_t        rsp
);
	import apspj_pkg::*;

	logic [VCNT_W-1:0]       vc_q;
	logic [VCNT_W-1:0]       n;
	logic [ECNT_W-1:0]       edge_total_q;
	logic                    cycle_q;
	logic                    ready_q;
	logic [MAX_VERTICES-1:0] reach_q;
	edge_t                   edge_mem [MAX_EDGES];
	edge_t                   edge_q;
	logic signed [DIST_W-1:0] val_mem [MAX_VERTICES];
	logic signed [DIST_W-1:0] tbl_mem [MAX_VERTICES * MAX_VERTICES];
	logic signed [DIST_W-1:0] a_q;
	logic signed [DIST_W-1:0] b_q;
	logic signed [DIST_W-1:0] tbl_q;
	logic [1:0]               q_status_q;
	logic                     q_table_q;
	logic signed [DIST_W-1:0] q_dist_q;
	rsp_t                     rsp_q;
	logic                     full;
	logic [VIDX_W-1:0]        src_idx;
	logic [VIDX_W-1:0]        dst_idx;
	logic                     usable;
	logic signed [DIST_W:0]   sum;
	logic                     lt;
	logic                     q_in_range;
	logic [VIDX_W-1:0]        qr_idx;
	logic [VIDX_W-1:0]        qc_idx;

	always_comb begin
		if (vc_q == '0) begin
			n = VCNT_W'(1);
		end else if (vc_q > VCNT_W'(MAX_VERTICES)) begin
			n = VCNT_W'(MAX_VERTICES);
		end else begin
			n = vc_q;
		end
	end

	assign full    = (edge_total_q >= ECNT_W'(MAX_EDGES));
	assign src_idx = VIDX_W'(edge_q.src - 5'd1);
	assign dst_idx = VIDX_W'(edge_q.dst - 5'd1);
	assign usable  = (edge_q.src != 5'd0) && (edge_q.src <= n) &&
		(edge_q.dst != 5'd0) && (edge_q.dst <= n);
	assign sum     = {a_q[DIST_W-1], a_q} + (DIST_W + 1)'(edge_q.w);
	assign lt      = sum < $signed({b_q[DIST_W-1], b_q});
	assign qr_idx  = VIDX_W'(req.query_row - 5'd1);
	assign qc_idx  = VIDX_W'(req.query_col - 5'd1);
	assign q_in_range = (req.query_row != 5'd0) && (req.query_row <= n) &&
		(req.query_col != 5'd0) && (req.query_col <= n);

	assign sts.edge_total = edge_total_q;
	assign sts.n          = n;
	assign sts.relax      = usable && reach_q[src_idx] && (!reach_q[dst_idx] || lt);
	assign sts.cycle      = cycle_q;
	assign rsp            = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q         <= VCNT_W'(MAX_VERTICES);
			edge_total_q <= '0;
			cycle_q      <= 1'b0;
			ready_q      <= 1'b0;
			reach_q      <= '0;
		end else begin
			if (cfg_we) begin
				vc_q    <= cfg_wdata;
				cycle_q <= 1'b0;
				ready_q <= 1'b0;
			end
			if (cmd.add_edge) begin
				cycle_q <= 1'b0;
				ready_q <= 1'b0;
				if (!full) begin
					edge_total_q <= edge_total_q + ECNT_W'(1);
				end
			end
			if (cmd.clear_edges) begin
				edge_total_q <= '0;
				cycle_q      <= 1'b0;
				ready_q      <= 1'b0;
			end
			if (cmd.run_start) begin
				cycle_q <= 1'b0;
				ready_q <= 1'b0;
			end
			if (cmd.set_ready) begin
				ready_q <= 1'b1;
			end
			if (cmd.set_cycle) begin
				cycle_q <= 1'b1;
			end
			if (cmd.reach_all) begin
				reach_q <= '1;
			end
			if (cmd.src_init) begin
				reach_q <= MAX_VERTICES'(1) << cmd.s;
			end
			if (cmd.relax_wr) begin
				reach_q[dst_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_edge && !full) begin
			edge_mem[EIDX_W'(edge_total_q)] <= '{src: req.edge_from, dst: req.edge_to,
				w: req.edge_weight};
		end
		if (cmd.edge_rd) begin
			edge_q <= edge_mem[cmd.k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.val_clr) begin
			val_mem[cmd.t] <= '0;
		end else if (cmd.src_init) begin
			val_mem[cmd.s] <= '0;
		end else if (cmd.relax_wr) begin
			val_mem[dst_idx] <= sum[DIST_W-1:0];
		end
		if (cmd.val_rd) begin
			a_q <= val_mem[src_idx];
			b_q <= val_mem[dst_idx];
		end else if (cmd.row_rd) begin
			a_q <= val_mem[cmd.t];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_wr) begin
			tbl_mem[{cmd.s, cmd.t}] <= reach_q[cmd.t] ? a_q : UNREACHABLE;
		end
		if (cmd.query) begin
			tbl_q <= tbl_mem[{qr_idx, qc_idx}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			q_table_q <= 1'b0;
			q_dist_q  <= '0;
			if (!ready_q) begin
				q_status_q <= ST_NOT_RUN;
			end else if (cycle_q) begin
				q_status_q <= ST_CYCLE;
			end else begin
				q_status_q <= ST_OK;
				q_table_q  <= q_in_range;
				q_dist_q   <= UNREACHABLE;
			end
		end
		if (cmd.out_ld) begin
			unique case (cmd.out_sel)
				OUT_ADD: begin
					rsp_q.status   <= full ? ST_FULL : ST_OK;
					rsp_q.distance <= '0;
				end
				OUT_ZERO: begin
					rsp_q.status   <= ST_OK;
					rsp_q.distance <= '0;
				end
				OUT_RUN: begin
					rsp_q.status   <= cycle_q ? ST_CYCLE : ST_OK;
					rsp_q.distance <= '0;
				end
				OUT_QUERY: begin
					rsp_q.status   <= q_status_q;
					rsp_q.distance <= q_table_q ? tbl_q : q_dist_q;
				end
				default: begin
					rsp_q.status   <= ST_OK;
					rsp_q.distance <= '0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

>>> src/apspj_ctrl.sv
// Controller: request handshake, result valid and the run sequencer.
`timescale 1ns / 1ps
`default_nettype none
module apspj_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire logic [1:0]      opcode,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	input  wire apspj_pkg::sts_t sts,
	output apspj_pkg::cmd_t      cmd
);
	import apspj_pkg::*;

	state_t            state_q, state_d;
	phase_t            phase_q, phase_d;
	logic [EIDX_W-1:0] k_q, k_d;
	logic [VCNT_W-1:0] r_q, r_d;
	logic [VIDX_W-1:0] s_q, s_d;
	logic [VIDX_W-1:0] t_q, t_d;
	logic              rsp_valid_q;
	logic              pass_end;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_POT;
			k_q         <= '0;
			r_q         <= '0;
			s_q         <= '0;
			t_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			k_q     <= k_d;
			r_q     <= r_d;
			s_q     <= s_d;
			t_q     <= t_d;
			if (cmd.out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		k_d      = k_q;
		r_d      = r_q;
		s_d      = s_q;
		t_d      = t_q;
		pass_end = 1'b0;
		cmd      = '0;
		cmd.out_sel = OUT_ZERO;
		cmd.k    = k_q;
		cmd.s    = s_q;
		cmd.t    = t_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && req_ready) begin
					unique case (opcode)
						OP_ADD: begin
							cmd.add_edge = 1'b1;
							cmd.out_ld   = 1'b1;
							cmd.out_sel  = OUT_ADD;
						end
						OP_CLEAR: begin
							cmd.clear_edges = 1'b1;
							cmd.out_ld      = 1'b1;
							cmd.out_sel     = OUT_ZERO;
						end
						OP_QUERY: begin
							cmd.query = 1'b1;
							state_d   = S_QRD;
						end
						OP_RUN: begin
							cmd.run_start = 1'b1;
							cmd.reach_all = 1'b1;
							t_d           = '0;
							state_d       = S_CLR;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_QRD: begin
				cmd.out_ld  = 1'b1;
				cmd.out_sel = OUT_QUERY;
				state_d     = S_IDLE;
			end
			S_CLR: begin
				cmd.val_clr = 1'b1;
				t_d         = t_q + VIDX_W'(1);
				if (t_q == VIDX_W'(MAX_VERTICES - 1)) begin
					phase_d = PH_POT;
					r_d     = '0;
					state_d = S_PASS;
				end
			end
			S_PASS: begin
				k_d = '0;
				if (sts.edge_total == '0) begin
					pass_end = 1'b1;
				end else begin
					state_d = S_ERD;
				end
			end
			S_ERD: begin
				cmd.edge_rd = 1'b1;
				state_d     = S_EVAL;
			end
			S_EVAL: begin
				cmd.val_rd = 1'b1;
				state_d    = S_EUPD;
			end
			S_EUPD: begin
				if (sts.relax) begin
					if (phase_q == PH_CHK) begin
						cmd.set_cycle = 1'b1;
					end else begin
						cmd.relax_wr = 1'b1;
					end
				end
				if (({1'b0, k_q} + ECNT_W'(1)) < sts.edge_total) begin
					k_d     = k_q + EIDX_W'(1);
					state_d = S_ERD;
				end else begin
					pass_end = 1'b1;
				end
			end
			S_CHKD: begin
				cmd.set_ready = 1'b1;
				if (sts.cycle) begin
					state_d = S_DONE;
				end else begin
					s_d     = '0;
					state_d = S_SINIT;
				end
			end
			S_SINIT: begin
				cmd.src_init = 1'b1;
				r_d          = '0;
				phase_d      = PH_SRC;
				t_d          = '0;
				if (sts.n > VCNT_W'(1)) begin
					state_d = S_PASS;
				end else begin
					state_d = S_RRD;
				end
			end
			S_RRD: begin
				cmd.row_rd = 1'b1;
				state_d    = S_RWR;
			end
			S_RWR: begin
				cmd.row_wr = 1'b1;
				if (({1'b0, t_q} + VCNT_W'(1)) < sts.n) begin
					t_d     = t_q + VIDX_W'(1);
					state_d = S_RRD;
				end else if (({1'b0, s_q} + VCNT_W'(1)) < sts.n) begin
					s_d     = s_q + VIDX_W'(1);
					state_d = S_SINIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.out_ld  = 1'b1;
				cmd.out_sel = OUT_RUN;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (pass_end) begin
			unique case (phase_q)
				PH_POT: begin
					state_d = S_PASS;
					if ((r_q + VCNT_W'(1)) < sts.n) begin
						r_d = r_q + VCNT_W'(1);
					end else begin
						phase_d = PH_CHK;
					end
				end
				PH_CHK: begin
					state_d = S_CHKD;
				end
				PH_SRC: begin
					if ((r_q + VCNT_W'(1)) < (sts.n - VCNT_W'(1))) begin
						r_d     = r_q + VCNT_W'(1);
						state_d = S_PASS;
					end else begin
						t_d     = '0;
						state_d = S_RRD;
					end
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

>>> src/all_pairs_shortest_path_johnson_core.sv
// Top level of the all-pairs shortest path core (Johnson scheme).
// Add-edge and clear requests register their result in the cycle they are accepted; a query
// registers the distance table entry and then loads the result register in state S_QRD. A run
// clears the vertex values, makes n potential passes and a check pass over the E stored edges,
// then for each of the n vertices in use as source makes n-1 passes and writes its table row;
// each edge is relaxed in three steps (edge store read, vertex value read, update).
// A run that finds a negative cycle ends after the check pass.
// Requests are taken again once the run result has been registered and no result is stalled.
`timescale 1ns / 1ps
`default_nettype none
module all_pairs_shortest_path_johnson_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire apspj_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output apspj_pkg::rsp_t      rsp,
	input  wire logic            cfg_we,
	input  wire logic [4:0]      cfg_wdata
);
	import apspj_pkg::*;

	cmd_t cmd;
	sts_t sts;

	apspj_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.opcode    (req.opcode),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	apspj_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

>>> src/apspj_chk.sv
// Port checker of the shortest path core and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "all_pairs_shortest_path_johnson_core_defines.svh"
module apspj_chk (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic            req_ready,
	input  wire apspj_pkg::req_t req,
	input  wire logic            rsp_valid,
	input  wire logic            rsp_ready,
	input  wire apspj_pkg::rsp_t rsp
);
	import apspj_pkg::*;

	// A stalled result holds until it is taken.
	`APSPJ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	// A request is never taken while a result is stuck in the output register.
	`APSPJ_ASSERT(a_no_overrun, req_valid && req_ready, !rsp_valid || rsp_ready)
	// Add and clear requests answer in the next cycle.
	`APSPJ_ASSERT_NEXT(a_fast_rsp, req_valid && req_ready &&
		(req.opcode == OP_ADD || req.opcode == OP_CLEAR), rsp_valid)
	// A query answers once its table read has been registered, with rsp_valid low and requests held off meanwhile.
	`APSPJ_ASSERT_NEXT(a_query_rsp, req_valid && req_ready && req.opcode == OP_QUERY,
		!rsp_valid && !req_ready ##1 rsp_valid)
endmodule

bind all_pairs_shortest_path_johnson_core apspj_chk u_apspj_chk (.*);
`default_nettype wire

>>> bench/all_pairs_shortest_path_johnson_core_tb.sv
// Self-checking testbench of the all-pairs shortest path core, with its own path predictor.
`timescale 1ns / 1ps
`default_nettype none
module all_pairs_shortest_path_johnson_core_tb;
	import apspj_pkg::*;

	localparam int IDLE_LIMIT = 300000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_we;
	logic [4:0] cfg_wdata;

	all_pairs_shortest_path_johnson_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	edge_t graph_edges[MAX_EDGES];
	int graph_edge_cnt;
	logic [4:0] vertex_reg;
	bit paths_valid;
	bit neg_cycle;
	int path_dist[MAX_VERTICES][MAX_VERTICES];

	rsp_t pending_rsp[$];
	int fail_count;
	int sent_count;
	int idle_cycles;
	bit no_gaps;
	int ready_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_vertices();
		if (vertex_reg < 1) return 1;
		if (vertex_reg > MAX_VERTICES) return MAX_VERTICES;
		return int'(vertex_reg);
	endfunction

	function automatic bit edge_in_graph(edge_t e, int n);
		return e.src >= 1 && e.src <= n && e.dst >= 1 && e.dst <= n;
	endfunction

	function automatic void solve_paths();
		int n;
		longint pot[MAX_VERTICES+1];
		longint d[MAX_VERTICES+1];
		bit reach[MAX_VERTICES+1];
		longint cand;
		n = active_vertices();
		foreach (pot[i]) pot[i] = 0;
		for (int r = 0; r < n; r++)
			for (int k = 0; k < graph_edge_cnt; k++) begin
				if (!edge_in_graph(graph_edges[k], n)) continue;
				cand = pot[graph_edges[k].src] + longint'(graph_edges[k].w);
				if (cand < pot[graph_edges[k].dst]) pot[graph_edges[k].dst] = cand;
			end
		neg_cycle = 1'b0;
		for (int k = 0; k < graph_edge_cnt; k++) begin
			if (!edge_in_graph(graph_edges[k], n)) continue;
			if (pot[graph_edges[k].src] + longint'(graph_edges[k].w) < pot[graph_edges[k].dst])
				neg_cycle = 1'b1;
		end
		paths_valid = 1'b1;
		if (neg_cycle) return;
		for (int s = 1; s <= n; s++) begin
			foreach (d[i]) begin
				d[i] = 0;
				reach[i] = 1'b0;
			end
			reach[s] = 1'b1;
			for (int r = 1; r < n; r++)
				for (int k = 0; k < graph_edge_cnt; k++) begin
					if (!edge_in_graph(graph_edges[k], n) || !reach[graph_edges[k].src]) continue;
					cand = d[graph_edges[k].src] + longint'(graph_edges[k].w);
					if (!reach[graph_edges[k].dst] || cand < d[graph_edges[k].dst]) begin
						d[graph_edges[k].dst] = cand;
						reach[graph_edges[k].dst] = 1'b1;
					end
				end
			for (int t = 1; t <= n; t++)
				path_dist[s-1][t-1] = reach[t] ? int'(d[t]) : int'(UNREACHABLE);
		end
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t e;
		int n;
		e.status = ST_OK;
		e.distance = '0;
		case (r.opcode)
			OP_ADD: begin
				paths_valid = 1'b0;
				neg_cycle = 1'b0;
				if (graph_edge_cnt >= MAX_EDGES) begin
					e.status = ST_FULL;
				end else begin
					graph_edges[graph_edge_cnt] = '{src: r.edge_from, dst: r.edge_to, w: r.edge_weight};
					graph_edge_cnt++;
				end
			end
			OP_RUN: begin
				solve_paths();
				e.status = neg_cycle ? ST_CYCLE : ST_OK;
			end
			OP_QUERY: begin
				n = active_vertices();
				if (!paths_valid) e.status = ST_NOT_RUN;
				else if (neg_cycle) e.status = ST_CYCLE;
				else if (r.query_row >= 1 && r.query_row <= n && r.query_col >= 1 && r.query_col <= n)
					e.distance = path_dist[r.query_row-1][r.query_col-1];
				else
					e.distance = UNREACHABLE;
			end
			default: begin
				graph_edge_cnt = 0;
				paths_valid = 1'b0;
				neg_cycle = 1'b0;
			end
		endcase
		return e;
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic [4:0] from, logic [4:0] to,
			logic [15:0] w, logic [4:0] row, logic [4:0] col);
		req_t r;
		r.opcode = op;
		r.edge_from = from;
		r.edge_to = to;
		r.edge_weight = w;
		r.query_row = row;
		r.query_col = col;
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		if (no_gaps) return 0;
		p = $urandom_range(99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_req(input req_t r);
		int gap;
		rsp_t exp_rsp;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		exp_rsp = predict_response(r);
		pending_rsp = {pending_rsp, exp_rsp};
		sent_count++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [4:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		vertex_reg = v;
		paths_valid = 1'b0;
		neg_cycle = 1'b0;
	endtask

	task automatic query_all(input int n);
		for (int s = 0; s <= n + 1; s++)
			for (int t = 0; t <= n + 1; t++)
				send_req(make_req(OP_QUERY, 5'($urandom), 5'($urandom), 16'($urandom), 5'(s), 5'(t)));
	endtask

	task automatic test_directed();
		send_req(make_req(OP_QUERY, 0, 0, 0, 1, 1));
		write_vertex_count(5'd4);
		send_req(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
		send_req(make_req(OP_ADD, 1, 2, 16'sd5, 0, 0));
		send_req(make_req(OP_ADD, 2, 3, -16'sd3, 0, 0));
		send_req(make_req(OP_ADD, 1, 3, 16'sd4, 0, 0));
		send_req(make_req(OP_ADD, 0, 1, 16'h8000, 0, 0));
		send_req(make_req(OP_ADD, 4, 31, 16'h7FFF, 0, 0));
		send_req(make_req(OP_QUERY, 0, 0, 0, 1, 3));
		send_req(make_req(OP_RUN, 0, 0, 0, 0, 0));
		send_req(make_req(OP_QUERY, 0, 0, 0, 1, 3));
		send_req(make_req(OP_QUERY, 0, 0, 0, 3, 1));
		send_req(make_req(OP_QUERY, 0, 0, 0, 4, 4));
		send_req(make_req(OP_QUERY, 0, 0, 0, 0, 2));
		send_req(make_req(OP_QUERY, 0, 0, 0, 31, 31));
		send_req(make_req(OP_ADD, 3, 1, -16'sd2, 0, 0));
		send_req(make_req(OP_RUN, 0, 0, 0, 0, 0));
		send_req(make_req(OP_QUERY, 0, 0, 0, 1, 2));
		send_req(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
		send_req(make_req(OP_QUERY, 0, 0, 0, 1, 2));
		send_req(make_req(OP_RUN, 0, 0, 0, 0, 0));
		send_req(make_req(OP_QUERY, 0, 0, 0, 2, 2));
		send_req(make_req(OP_QUERY, 0, 0, 0, 1, 2));
	endtask

	task automatic test_store_full();
		write_vertex_count(5'd16);
		send_req(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
		for (int i = 0; i < MAX_EDGES + 2; i++)
			send_req(make_req(OP_ADD, 5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
				16'($urandom_range(0, 1000)), 0, 0));
		send_req(make_req(OP_RUN, 0, 0, 0, 0, 0));
		for (int i = 0; i < 12; i++)
			send_req(make_req(OP_QUERY, 0, 0, 0, 5'($urandom_range(1, 16)), 5'($urandom_range(1, 16))));
		send_req(make_req(OP_QUERY, 0, 0, 0, 16, 16));
	endtask

	task automatic test_vertex_limits();
		write_vertex_count(5'd0);
		send_req(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
		send_req(make_req(OP_ADD, 1, 1, 16'sd7, 0, 0));
		send_req(make_req(OP_ADD, 1, 2, 16'sd7, 0, 0));
		send_req(make_req(OP_RUN, 0, 0, 0, 0, 0));
		query_all(1);
		write_vertex_count(5'd31);
		send_req(make_req(OP_ADD, 16, 1, 16'sd9, 0, 0));
		send_req(make_req(OP_ADD, 17, 1, -16'sd9, 0, 0));
		send_req(make_req(OP_RUN, 0, 0, 0, 0, 0));
		for (int i = 0; i < 6; i++)
			send_req(make_req(OP_QUERY, 0, 0, 0, 5'($urandom_range(14, 18)), 5'($urandom_range(0, 2))));
		write_vertex_count(5'd1);
		send_req(make_req(OP_ADD, 1, 1, -16'sd1, 0, 0));
		send_req(make_req(OP_RUN, 0, 0, 0, 0, 0));
		send_req(make_req(OP_QUERY, 0, 0, 0, 1, 1));
	endtask

	task automatic test_random_graphs();
		int n;
		int ne;
		logic [15:0] w;
		while (sent_count < 490) begin
			no_gaps = ($urandom_range(3) == 0);
			if ($urandom_range(3) == 0)
				write_vertex_count($urandom_range(5) == 0 ? 5'($urandom) : 5'($urandom_range(1, 6)));
			n = active_vertices();
			if ($urandom_range(4) != 0) send_req(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
			ne = $urandom_range(1, 10);
			for (int i = 0; i < ne; i++) begin
				w = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200) - 20);
				if ($urandom_range(9) == 0)
					send_req(make_req(OP_ADD, 5'($urandom), 5'($urandom), w, 5'($urandom), 5'($urandom)));
				else
					send_req(make_req(OP_ADD, 5'($urandom_range(1, n)), 5'($urandom_range(1, n)), w,
						5'($urandom), 5'($urandom)));
			end
			if ($urandom_range(5) == 0)
				send_req(make_req(2'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
					5'($urandom), 5'($urandom)));
			send_req(make_req(OP_RUN, 5'($urandom), 5'($urandom), 16'($urandom), 5'($urandom),
				5'($urandom)));
			for (int i = $urandom_range(3, 10); i > 0; i--)
				if ($urandom_range(7) == 0)
					send_req(make_req(OP_QUERY, 5'($urandom), 5'($urandom), 16'($urandom),
						5'($urandom), 5'($urandom)));
				else
					send_req(make_req(OP_QUERY, 5'($urandom), 5'($urandom), 16'($urandom),
						5'($urandom_range(1, n)), 5'($urandom_range(1, n))));
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			ready_hold <= 0;
		end else if (no_gaps) begin
			rsp_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			rsp_ready <= 1'b0;
		end else if ($urandom_range(99) < 3) begin
			ready_hold <= $urandom_range(10, 30);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) < 75);
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response status %0d distance %0d", $time, rsp.status,
					rsp.distance);
				fail_count++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
					fail_count++;
				end
				if (rsp.distance !== e.distance) begin
					$display("%0t: distance expected %0d actual %0d", $time, e.distance,
						rsp.distance);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sent_count = 0;
		no_gaps = 1'b0;
		vertex_reg = 5'd16;
		graph_edge_cnt = 0;
		paths_valid = 1'b0;
		neg_cycle = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_vertex_limits();
		test_store_full();
		test_random_graphs();
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> all_pairs_shortest_path_johnson_core.f
+incdir+src
src/apspj_pkg.sv
src/apspj_dp.sv
src/apspj_ctrl.sv
src/all_pairs_shortest_path_johnson_core.sv
src/apspj_chk.sv
bench/all_pairs_shortest_path_johnson_core_tb.sv
